/* design/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Opcodes, widths and the queue entry type passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
	localparam int FRAC_W = 8;
	localparam int DW = 32;
	// divide: quotient of (|a| << FRAC_W) by |b|, one bit per stage
	localparam int QW = DW + FRAC_W;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
		OP_MIN = 4'd12, OP_MAX = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} op_t;

	// item class chosen by the front end
	typedef enum logic [1:0] {
		CL_SIMPLE = 2'd0, CL_MUL = 2'd1, CL_DIV = 2'd2
	} cls_t;

	typedef struct packed {
		cls_t             cls;
		logic             neg;      // sign of mul/div result
		logic             dz;
		logic             cmp;
		logic [DW-1:0]    res;      // simple result
		logic [DW-1:0]    mag_a;
		logic [DW-1:0]    mag_b;
	} entry_t;

	function automatic logic [DW-1:0] sat(input logic neg, input logic [2*DW-1:0] q);
		logic [DW-1:0] r;
		if (neg) begin
			if (q >= (2*DW)'(64'h8000_0000)) r = {1'b1, {(DW-1){1'b0}}};
			else r = DW'(0) - q[DW-1:0];
		end else begin
			if (q > (2*DW)'(64'h7FFF_FFFF)) r = {1'b0, {(DW-1){1'b1}}};
			else r = q[DW-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

/* design/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front: decode and classify
// Computes simple ops outright, flags divide by zero, prepares magnitudes and sign for mul/div.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_front (
	input  wire logic [3:0]  mode,
	input  wire logic signed [31:0] operand_a,
	input  wire logic signed [31:0] operand_b,
	output fpa_pkg::entry_t  entry
);
	import fpa_pkg::*;
	logic lt, eq;
	logic [DW-1:0] ua, ub;
	always_comb begin
		ua = operand_a;
		ub = operand_b;
		lt = operand_a < operand_b;
		eq = operand_a == operand_b;
		entry = '0;
		entry.cls = CL_SIMPLE;
		entry.mag_a = operand_a[DW-1] ? DW'(0) - ua : ua;
		entry.mag_b = operand_b[DW-1] ? DW'(0) - ub : ub;
		entry.neg = (operand_a[DW-1] ^ operand_b[DW-1]) && (ua != '0);
		case (op_t'(mode))
			OP_ADD: entry.res = ua + ub;
			OP_SUB: entry.res = ua - ub;
			OP_MUL: begin
				entry.cls = CL_MUL;
				entry.neg = entry.neg && (ub != '0);
			end
			OP_DIV: begin
				if (ub == '0) entry.dz = 1'b1;
				else entry.cls = CL_DIV;
			end
			OP_GT: entry.cmp = !lt && !eq;
			OP_LT: entry.cmp = lt;
			OP_GE: entry.cmp = !lt;
			OP_LE: entry.cmp = lt || eq;
			OP_EQ: entry.cmp = eq;
			OP_NE: entry.cmp = !eq;
			OP_INC: entry.res = ua + DW'(1);
			OP_DEC: entry.res = ua - DW'(1);
			OP_MIN: entry.res = lt ? ua : ub;
			OP_MAX: entry.res = (!lt && !eq) ? ua : ub;
			OP_FROM_INT: entry.res = ua << FRAC_W;
			OP_TO_INT: entry.res = DW'(operand_a >>> FRAC_W);
			default: entry.res = '0;
		endcase
	end
endmodule
`default_nettype wire

/* design/fpa_queue.sv */
// ----------------------------------------------------------------------------
// fpa_queue: short FIFO between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  fpa_pkg::entry_t      din,
	input  wire logic            pop,
	output fpa_pkg::entry_t      dout,
	output logic                 empty,
	output logic                 full
);
	import fpa_pkg::*;
	entry_t mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0] cnt_q;
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end
	assign dout = mem_q[rp_q];
	assign empty = cnt_q == '0;
	assign full = cnt_q == (QAW+1)'(QDEPTH);
endmodule
`default_nettype wire

/* design/fpa_back.sv */
// ----------------------------------------------------------------------------
// fpa_back: execution pipeline
// Registered 32x32 multiply, then a restoring divider of QW+1 stages,
// then rounding/saturation. Every item walks all stages in order.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  fpa_pkg::entry_t      in_entry,
	output logic                 strobe,
	output logic [31:0]          result_value,
	output logic                 compare_true,
	output logic                 divide_by_zero
);
	import fpa_pkg::*;
	localparam int NS = QW + 1;  // divider stages, last one gives round bit
	localparam int RW = DW + 1;

	// stage 1: multiply
	entry_t e_s1;
	logic v_s1;
	logic [2*DW-1:0] prod_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		e_s1 <= in_entry;
		prod_s1 <= in_entry.mag_a * in_entry.mag_b;
	end

	// divider stages: numerator (mag_a << FRAC_W), bit NS-1 ... with
	// an extra fraction bit for rounding
	localparam int NW = QW + 1;
	entry_t e_d [NS+1];
	logic v_d [NS+1];
	logic [2*DW-1:0] p_d [NS+1];
	logic [NW-1:0] n_d [NS+1];
	logic [RW-1:0] r_d [NS+1];
	logic [NW-1:0] q_d [NS+1];
	always_comb begin
		e_d[0] = e_s1;
		v_d[0] = v_s1;
		p_d[0] = prod_s1;
		n_d[0] = {e_s1.mag_a, {(FRAC_W+1){1'b0}}};
		r_d[0] = '0;
		q_d[0] = '0;
	end
	for (genvar i = 0; i < NS; i++) begin : g_div
		logic [RW-1:0] t;
		logic ge;
		always_comb begin
			t = {r_d[i][RW-2:0], n_d[i][NW-1]};
			ge = t >= {1'b0, e_d[i].mag_b};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[i+1] <= 1'b0;
			else v_d[i+1] <= v_d[i];
		end
		always_ff @(posedge clk) begin
			e_d[i+1] <= e_d[i];
			p_d[i+1] <= p_d[i];
			n_d[i+1] <= n_d[i] << 1;
			r_d[i+1] <= ge ? t - {1'b0, e_d[i].mag_b} : t;
			q_d[i+1] <= {q_d[i][NW-2:0], ge};
		end
	end

	// final: round and saturate; full 64-bit magnitude so large products saturate
	logic [2*DW-1:0] qm, qd;
	logic [DW-1:0] res;
	always_comb begin
		qm = (p_d[NS] + (2*DW)'(1 << (FRAC_W-1))) >> FRAC_W;
		qd = (2*DW)'(q_d[NS][NW-1:1]) + (2*DW)'(q_d[NS][0]);
		case (e_d[NS].cls)
			CL_MUL: res = sat(e_d[NS].neg, qm);
			CL_DIV: res = sat(e_d[NS].neg, qd);
			default: res = e_d[NS].res;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= v_d[NS];
	end
	always_ff @(posedge clk) begin
		result_value <= res;
		compare_true <= e_d[NS].cmp;
		divide_by_zero <= e_d[NS].dz;
	end
endmodule
`default_nettype wire

/* design/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu: signed Q-format ALU on raw 32-bit values
// Add/sub/compare/min/max/conversions plus exact rounded, saturated mul/div.
// ----------------------------------------------------------------------------
// Usage:
//  - Drive mode/operand_a/operand_b with start high; the transfer happens at
//    a rising edge where start is high and busy is low.
//  - Each transfer yields one result, shown for one cycle with done high.
//    The receiver cannot stall; results come in transfer order.
//  - Front end classifies the item and computes simple opcodes, then the
//    entry enters a 4-deep queue. The back end pops one entry per cycle
//    into a fixed pipeline: multiplier register, FRAC_W+33 restoring
//    divider stages (one quotient bit each), then the round/saturate
//    output register.
//  - The path from a transfer to its done pulse runs through the queue, the
//    multiplier register, the divider stages and the output register.
//  - Throughput: one item per cycle, sustained.
//  - busy rises only if the queue fills, which the back end never lets
//    happen since it drains every cycle.
//  - Reset (arst_n low) empties queue and pipeline; no results pending.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_point_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  mode,
	input  wire logic signed [31:0] operand_a,
	input  wire logic signed [31:0] operand_b,
	output logic             done,
	output logic signed [31:0] result_value,
	output logic             compare_true,
	output logic             divide_by_zero
);
	import fpa_pkg::*;
	entry_t fe, qe;
	logic empty, full, push, pop;
	logic [31:0] rv;

	fpa_front u_front (.mode(mode), .operand_a(operand_a), .operand_b(operand_b),
		.entry(fe));

	assign busy = full;
	assign push = start && !full;
	assign pop = !empty;   // back end always takes an entry

	fpa_queue u_queue (.clk(clk), .arst_n(arst_n), .push(push), .din(fe),
		.pop(pop), .dout(qe), .empty(empty), .full(full));

	fpa_back u_back (.clk(clk), .arst_n(arst_n), .in_valid(pop), .in_entry(qe),
		.strobe(done), .result_value(rv), .compare_true(compare_true),
		.divide_by_zero(divide_by_zero));

	assign result_value = rv;
endmodule
`default_nettype wire

/* design/fpa_checker.sv */
// ----------------------------------------------------------------------------
// fpa_checker: port-level checks for fixed_point_alu
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [31:0] result_value,
	input wire logic        compare_true,
	input wire logic        divide_by_zero
);
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && compare_true |-> result_value == 32'd0) else $error("cmp value");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> result_value == 32'd0 && !compare_true)
		else $error("dz value");
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy");
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |=> !done || $past(arst_n)) else $error("done after reset");
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done), .result_value(result_value),
	.compare_true(compare_true), .divide_by_zero(divide_by_zero));
`default_nettype wire
